// ----- hw/rtl/ftlb_pkg.sv -----
// Shared types and constants for the fully associative translation buffer.
// No dependencies; ftlb_repl, ftlb_table and fifo_tlb_core import this package.
package ftlb_pkg;

    localparam int CFG_W       = 5;
    localparam int OUT_FRAME_W = 32;
    localparam int COUNT_W     = 5;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd31;

    typedef enum logic [1:0] {
        CMD_LOOKUP    = 2'd0,
        CMD_INSERT    = 2'd1,
        CMD_INV_PAGE  = 2'd2,
        CMD_INV_FRAME = 2'd3
    } cmd_t;

    typedef struct packed {
        logic fire;
        cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        logic                   hit;
        logic [OUT_FRAME_W-1:0] found_frame;
        logic [COUNT_W-1:0]     cleared_count;
    } rslt_t;

endpackage

// ----- hw/rtl/ftlb_req_if.sv -----
// Request channel of the translation buffer: command, page and frame.
// Depends on nothing; page and frame widths follow the block parameters.
interface ftlb_req_if #(
    parameter int PAGE_BITS  = 52,
    parameter int FRAME_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [PAGE_BITS-1:0]  page_number;
    logic [FRAME_BITS-1:0] phys_frame;

    modport source (output valid, output cmd, output page_number, output phys_frame,
                    input ready);
    modport sink   (input valid, input cmd, input page_number, input phys_frame,
                    output ready);
endinterface

// ----- hw/rtl/ftlb_rsp_if.sv -----
// Response channel of the translation buffer: hit, frame and clear count.
// Depends on nothing; field widths are fixed.
interface ftlb_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] found_frame;
    logic [4:0]  cleared_count;

    modport source (output valid, output hit, output found_frame, output cleared_count,
                    input ready);
    modport sink   (input valid, input hit, input found_frame, input cleared_count,
                    output ready);
endinterface

// ----- hw/rtl/ftlb_repl.sv -----
// Entry-count register and round-robin replacement pointer.
// Depends on ftlb_pkg; produces the active-slot mask and the insert slot.
module ftlb_repl
    import ftlb_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_W-1:0]               cfg_wdata,
    input  logic                           advance,
    output logic [MAX_ENTRIES-1:0]         active,
    output logic [$clog2(MAX_ENTRIES)-1:0] slot
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] entries_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic [NW-1:0]    n;
    logic [NW-1:0]    slot_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= CFG_RESET;
            slot_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
            if (advance)
            begin
                slot_reg <= slot_next;
            end
        end
    end

    always_comb
    begin
        // clamp the programmed count to 1..MAX_ENTRIES
        n = NW'(entries_reg);
        if (n == '0)
        begin
            n = NW'(1);
        end
        else if (n > NW'(MAX_ENTRIES))
        begin
            n = NW'(MAX_ENTRIES);
        end

        // a pointer left beyond a shrunk count restarts at slot 0
        slot = (NW'(slot_reg) >= n) ? '0 : slot_reg;
        slot_inc = NW'(slot) + NW'(1);
        slot_next = (slot_inc >= n) ? '0 : slot_inc[IDX_W-1:0];

        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            active[i] = (NW'(i) < n);
        end
    end

endmodule

// ----- hw/rtl/ftlb_table.sv -----
// Entry storage with parallel page and frame compare, and table update.
// Depends on ftlb_pkg; driven by the core's input stage.
module ftlb_table
    import ftlb_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int PAGE_BITS   = 52,
    parameter int FRAME_BITS  = 32
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctrl_t                          ctrl,
    input  logic [PAGE_BITS-1:0]           page,
    input  logic [FRAME_BITS-1:0]          frame,
    input  logic [MAX_ENTRIES-1:0]         active,
    input  logic [$clog2(MAX_ENTRIES)-1:0] slot,
    output rslt_t                          result
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int NW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [PAGE_BITS-1:0]            page_store_reg  [MAX_ENTRIES];
    logic [FRAME_BITS-1:0]           frame_store_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]          valid_reg;
    logic [MAX_ENTRIES-1:0]          valid_next;

    logic [MAX_ENTRIES-1:0]          page_match;
    logic [MAX_ENTRIES-1:0]          frame_match;
    logic [MAX_ENTRIES-1:0]          page_first;
    logic [MAX_ENTRIES-1:0]          clear_vec;
    logic [FRAME_BITS-1:0]           found;
    logic [FRAME_BITS+OUT_FRAME_W-1:0] found_wide;
    logic [CNT_W-1:0]                frame_hits;
    logic                            is_lookup;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            page_match[i]  = valid_reg[i] && active[i] && (page_store_reg[i] == page);
            frame_match[i] = valid_reg[i] && active[i] && (frame_store_reg[i] == frame);
        end

        // isolate the lowest-index page match
        page_first = page_match & (~page_match + MAX_ENTRIES'(1));

        found = '0;
        frame_hits = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            found = found | (frame_store_reg[i] & {FRAME_BITS{page_first[i]}});
            frame_hits = frame_hits + CNT_W'(frame_match[i]);
        end

        is_lookup = (ctrl.cmd == CMD_LOOKUP);
        found_wide = {{OUT_FRAME_W{1'b0}}, found & {FRAME_BITS{is_lookup}}};

        result.hit = is_lookup && (|page_match);
        result.found_frame = found_wide[OUT_FRAME_W-1:0];

        case (ctrl.cmd)
            CMD_INV_PAGE:
            begin
                clear_vec = page_first;
                result.cleared_count = COUNT_W'(|page_match);
            end
            CMD_INV_FRAME:
            begin
                clear_vec = frame_match;
                // saturate the count; only reachable with more than 31 slots
                if (NW'(frame_hits) > NW'(COUNT_SAT))
                begin
                    result.cleared_count = COUNT_SAT;
                end
                else
                begin
                    result.cleared_count = COUNT_W'(frame_hits);
                end
            end
            default:
            begin
                clear_vec = '0;
                result.cleared_count = '0;
            end
        endcase

        valid_next = valid_reg & ~clear_vec;
        if (ctrl.cmd == CMD_INSERT)
        begin
            valid_next[slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.fire)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire && (ctrl.cmd == CMD_INSERT))
        begin
            page_store_reg[slot]  <= page;
            frame_store_reg[slot] <= frame;
        end
    end

endmodule

// ----- hw/rtl/fifo_tlb_core.sv -----
// Fully associative translation buffer with round-robin replacement.
//
// Channels: req carries one command per transaction (lookup, insert,
// invalidate by page, invalidate by frame) with a page and a frame number;
// rsp returns exactly one transaction per request: hit, found_frame and
// cleared_count. cfg_we/cfg_wdata set the number of slots in use (0 acts
// as 1, values above MAX_ENTRIES act as MAX_ENTRIES); write it while idle.
//
// Flow: a request accepted at an edge is registered in the input stage, compared
// against all slots from that register, and its result is loaded into the
// response register when rsp is free. Throughput is one command per cycle while
// rsp does not stall: the table is updated at the same edge that loads the
// response register, so a following command sees the result of the one before
// it. The rate is set by the parallel compare over all slots.
//
// Reset clears all valid bits, the replacement pointer, and sets the slot
// count to 16. When rsp stalls, the response register holds, the input
// stage fills, and req.ready drops until rsp takes the pending transaction.
// Depends on ftlb_pkg, ftlb_req_if, ftlb_rsp_if, ftlb_repl and ftlb_table.
module fifo_tlb_core
    import ftlb_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int PAGE_BITS   = 52,
    parameter int FRAME_BITS  = 32
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ftlb_req_if.sink         req,
    ftlb_rsp_if.source       rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    logic                  s1_valid_reg;
    cmd_t                  s1_cmd_reg;
    logic [PAGE_BITS-1:0]  s1_page_reg;
    logic [FRAME_BITS-1:0] s1_frame_reg;

    logic                  out_valid_reg;
    rslt_t                 out_reg;

    logic                  out_free;
    logic                  s1_fire;
    logic                  req_fire;
    ctrl_t                 ctrl;
    rslt_t                 result;
    logic [MAX_ENTRIES-1:0] active;
    logic [IDX_W-1:0]      slot;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_fire  = req.valid && req.ready;

    assign ctrl.fire = s1_fire;
    assign ctrl.cmd  = s1_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_cmd_reg   <= cmd_t'(req.cmd);
            s1_page_reg  <= req.page_number;
            s1_frame_reg <= req.phys_frame;
        end
        if (s1_fire)
        begin
            out_reg <= result;
        end
    end

    ftlb_repl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_repl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (s1_fire && (s1_cmd_reg == CMD_INSERT)),
        .active    (active),
        .slot      (slot)
    );

    ftlb_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .page   (s1_page_reg),
        .frame  (s1_frame_reg),
        .active (active),
        .slot   (slot),
        .result (result)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_reg.hit;
    assign rsp.found_frame   = out_reg.found_frame;
    assign rsp.cleared_count = out_reg.cleared_count;

endmodule
